[design/clq_pkg.sv]
// Package for the circular linked queue manager.
// Holds sizes, widths, operation and status codes, and the word types.
// No dependencies.
package clq_pkg;

	localparam int NUM_ELEMS  = 16;
	localparam int NUM_QUEUES = 4;

	localparam int ELEM_W  = $clog2(NUM_ELEMS);
	localparam int QUEUE_W = $clog2(NUM_QUEUES);
	localparam int CNT_W   = $clog2(NUM_ELEMS + 1);

	typedef enum logic {
		OP_APPEND = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_QUEUED = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_NOT_IN = 2'd3
	} status_t;

	typedef struct packed {
		op_t                op;
		logic [QUEUE_W-1:0] queue_id;
		logic [ELEM_W-1:0]  elem_id;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [CNT_W-1:0]   queue_len;
		logic               head_valid;
		logic [ELEM_W-1:0]  head_elem;
	} res_t;

endpackage

[design/clq_engine.sv]
// Queue state and single-pass update logic for the circular linked queue manager.
// Keeps ring links, membership tags, owners, heads and counts in flip-flops.
// Depends on clq_pkg.
module clq_engine import clq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_en,
	input  req_t req,
	output res_t res
);

	logic [ELEM_W-1:0]  next_q  [NUM_ELEMS];
	logic [ELEM_W-1:0]  prev_q  [NUM_ELEMS];
	logic [QUEUE_W-1:0] owner_q [NUM_ELEMS];
	logic [NUM_ELEMS-1:0] tag_q;
	logic [ELEM_W-1:0]  head_q  [NUM_QUEUES];
	logic [CNT_W-1:0]   count_q [NUM_QUEUES];

	logic [ELEM_W-1:0] e, h, prev_addr, pv_rd, nx_rd;
	logic [QUEUE_W-1:0] q;
	logic [CNT_W-1:0] cnt;
	logic is_member;

	logic nxa_we, nxb_we, pva_we, pvb_we;
	logic [ELEM_W-1:0] nxa_addr, nxa_data, nxb_addr, nxb_data;
	logic [ELEM_W-1:0] pva_addr, pva_data, pvb_addr, pvb_data;
	logic head_we, cnt_we, tag_we, tag_data;
	logic [ELEM_W-1:0] head_data;
	logic [CNT_W-1:0] cnt_data;
	logic [CNT_W-1:0] new_cnt;
	logic [ELEM_W-1:0] new_head;
	status_t st;

	assign e = req.elem_id;
	assign q = req.queue_id;
	assign h = head_q[q];
	assign cnt = count_q[q];
	assign is_member = tag_q[e];
	assign prev_addr = (req.op == OP_REMOVE) ? e : h;
	assign pv_rd = prev_q[prev_addr];
	assign nx_rd = next_q[e];

	always_comb begin
		st = ST_DONE;
		nxa_we = 1'b0; nxa_addr = e; nxa_data = e;
		nxb_we = 1'b0; nxb_addr = pv_rd; nxb_data = e;
		pva_we = 1'b0; pva_addr = e; pva_data = e;
		pvb_we = 1'b0; pvb_addr = h; pvb_data = e;
		head_we = 1'b0; head_data = e;
		cnt_we = 1'b0; cnt_data = cnt;
		tag_we = 1'b0; tag_data = 1'b0;
		case (req.op)
			OP_APPEND: begin
				if (is_member) begin
					st = ST_QUEUED;
				end else begin
					tag_we = 1'b1;
					tag_data = 1'b1;
					cnt_we = 1'b1;
					cnt_data = cnt + CNT_W'(1);
					nxa_we = 1'b1;
					pva_we = 1'b1;
					if (cnt == '0) begin
						head_we = 1'b1;
						head_data = e;
					end else begin
						nxa_data = h;
						pva_data = pv_rd;
						nxb_we = 1'b1;
						nxb_addr = pv_rd;
						nxb_data = e;
						pvb_we = 1'b1;
						pvb_addr = h;
						pvb_data = e;
					end
				end
			end
			OP_REMOVE: begin
				if (cnt == '0) begin
					st = ST_EMPTY;
				end else if (!is_member || owner_q[e] != q) begin
					st = ST_NOT_IN;
				end else begin
					nxb_we = 1'b1;
					nxb_addr = pv_rd;
					nxb_data = nx_rd;
					pvb_we = 1'b1;
					pvb_addr = nx_rd;
					pvb_data = pv_rd;
					cnt_we = 1'b1;
					cnt_data = cnt - CNT_W'(1);
					tag_we = 1'b1;
					tag_data = 1'b0;
					if (h == e) begin
						head_we = 1'b1;
						head_data = (cnt == CNT_W'(1)) ? '0 : nx_rd;
					end
				end
			end
			default: begin
				st = ST_DONE;
			end
		endcase
	end

	assign new_cnt = cnt_we ? cnt_data : cnt;
	assign new_head = head_we ? head_data : h;

	always_comb begin
		res.status = st;
		res.queue_len = new_cnt;
		res.head_valid = (new_cnt != '0);
		res.head_elem = (new_cnt != '0) ? new_head : '0;
	end

	always_ff @(posedge clk) begin
		if (req_en) begin
			for (int i = 0; i < NUM_ELEMS; i++) begin
				if (nxa_we && nxa_addr == ELEM_W'(i)) begin
					next_q[i] <= nxa_data;
				end
				if (nxb_we && nxb_addr == ELEM_W'(i)) begin
					next_q[i] <= nxb_data;
				end
				if (pva_we && pva_addr == ELEM_W'(i)) begin
					prev_q[i] <= pva_data;
				end
				if (pvb_we && pvb_addr == ELEM_W'(i)) begin
					prev_q[i] <= pvb_data;
				end
			end
			if (tag_we && tag_data) begin
				owner_q[e] <= q;
			end
			if (head_we) begin
				head_q[q] <= head_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
			for (int j = 0; j < NUM_QUEUES; j++) begin
				count_q[j] <= '0;
			end
		end else if (req_en) begin
			if (tag_we) begin
				tag_q[e] <= tag_data;
			end
			if (cnt_we) begin
				count_q[q] <= cnt_data;
			end
		end
	end

endmodule

[design/circular_linked_queue_manager.sv]
// Circular linked queue manager: input register, single-pass update, result register.
// An accepted word waits in the input register; its result goes to the result register.
// Throughput: one word per cycle if out_ready does not stall, set by the single pass.
// Reset clears membership tags and queue counts at once; links and heads need no clearing.
// Depends on clq_pkg and clq_engine.
module circular_linked_queue_manager import clq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic [QUEUE_W-1:0] queue_id,
	input  logic [ELEM_W-1:0]  elem_id,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [CNT_W-1:0]   queue_len,
	output logic               head_valid,
	output logic [ELEM_W-1:0]  head_elem
);

	logic valid_s1;
	req_t req_s1;
	logic advance;
	res_t res_comb;
	res_t res_q;
	logic out_valid_q;

	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1.op <= op_t'(op);
			req_s1.queue_id <= queue_id;
			req_s1.elem_id <= elem_id;
		end
		if (advance) begin
			res_q <= res_comb;
		end
	end

	clq_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.req_en (advance),
		.req    (req_s1),
		.res    (res_comb)
	);

	assign out_valid = out_valid_q;
	assign status = res_q.status;
	assign queue_len = res_q.queue_len;
	assign head_valid = res_q.head_valid;
	assign head_elem = res_q.head_elem;

`ifndef NO_ASSERTIONS
	a_size_head: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (head_valid == (queue_len != '0)))
		else $error("head_valid disagrees with queue_len");

	a_empty_size: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_EMPTY) |-> (queue_len == '0 && head_elem == '0))
		else $error("empty status with nonzero size or head");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("processed word did not reach the result register");
`endif

endmodule
